// ===== rtl/nfwm_pkg.sv =====
package nfwm_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COUNT_BITS     = 16;
   localparam int MEAN_FRAC_BITS = 16;
   localparam int MEAN_BITS      = SAMPLE_BITS + MEAN_FRAC_BITS;
   localparam int DELTA_BITS     = MEAN_BITS + 1;
   localparam int PROD_BITS      = 2 * DELTA_BITS;
   localparam int SQ_FRAC        = 4;
   localparam int PROD_SHIFT     = 2 * MEAN_FRAC_BITS - SQ_FRAC;
   localparam int TERM_BITS      = PROD_BITS - PROD_SHIFT;
   localparam int SUM_BITS       = 64;
   localparam int DIV_BITS       = 64;
   localparam int DIVISOR_BITS   = 24;
   localparam int SIGMA_BITS     = 32;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int MIN_VALID      = 2;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SAMPLE_COUNT  = 3'd0,
      CSR_MIN_SAMPLES   = 3'd1,
      CSR_MAX_ERR_FRAC  = 3'd2,
      CSR_COUNTS_PER_G  = 3'd3,
      CSR_GOOD_SIGMA    = 3'd4,
      CSR_DEGR_SIGMA    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_COMPLETED  = 2'd0,
      ST_TOO_FEW    = 2'd1,
      ST_READ_ERR   = 2'd2,
      ST_FEW_VALID  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      Q_GOOD     = 2'd0,
      Q_DEGRADED = 2'd1,
      Q_FAILED   = 2'd2
   } quality_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_MEAN,
      S_MUL,
      S_ERRCHK,
      S_CHECK,
      S_FIN,
      S_VAR,
      S_SQRT,
      S_GDIV,
      S_QUAL
   } state_type;

   typedef struct packed {
      logic                          req_type;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          read_error;
   } req_data_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [1:0]            quality;
      logic [SIGMA_BITS-1:0] sigma_counts;
      logic [SIGMA_BITS-1:0] sigma_grams;
      logic [COUNT_BITS-1:0] valid_total;
      logic [COUNT_BITS-1:0] error_total;
   } rsp_data_type;

endpackage

// ===== rtl/nfwm_div.sv =====
module nfwm_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [nfwm_pkg::DIV_BITS-1:0]     dividend,
   input  logic [nfwm_pkg::DIVISOR_BITS-1:0] divisor,
   output logic                              done,
   output logic [nfwm_pkg::DIV_BITS-1:0]     quotient
);
   import nfwm_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_BITS);

   logic [DIV_BITS-1:0]     dvd_ff, dvd_in;
   logic [DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [DIVISOR_BITS:0]   rem_sh;
   logic                    fits;

   // one restoring step per cycle, quotient bits shift into the dividend register
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DIV_BITS-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // remainder stays below the divisor, so it fits the divisor width
         rem_in = fits ? DIVISOR_BITS'(rem_sh - {1'b0, dvs_ff})
                       : rem_sh[DIVISOR_BITS-1:0];
         dvd_in = {dvd_ff[DIV_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(DIV_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== rtl/noise_floor_welford_meter.sv =====
// Noise floor meter: running Welford mean and variance of converter readings.
// Requests enter on req_data with start; a request is taken at a clock edge
// where start is high and busy is low. A request with req_type set opens a
// measurement run of sample_count items and clears the accumulators; sample
// requests then update the running mean and the sum of squared deviations,
// failed reads are only counted. Sample requests outside a run are dropped.
// At most one result per request appears on rsp_data with rsp_valid high for
// one cycle; the receiver must take it then, there is no back-pressure.
// Flow, from the accepting edge until the block can accept again:
// a start request leaves the block idle (its result, if any, is registered
// at the accepting edge); a valid sample runs the 64-step serial divide of
// the mean update, the 41-step shift-add multiply and a run check; a
// failed read has an error check, then a run check unless it aborts.
// The last item of a run adds the 64-step variance divide, the square root,
// the 64-step grams divide and a classify step; a saturated variance or a
// zero counts_per_gram skips the later steps. Registers are written on csr_we;
// the user must write them only while idle; the block itself does not enforce
// it. sample_count is latched when a run opens. Synchronous reset loads
// register defaults and closes any run; no result is pending after reset.
module noise_floor_welford_meter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  nfwm_pkg::req_data_type             req_data,
   output logic                               rsp_valid,
   output nfwm_pkg::rsp_data_type             rsp_data,
   input  logic                               csr_we,
   input  logic [nfwm_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [nfwm_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import nfwm_pkg::*;

   // configuration
   logic [COUNT_BITS-1:0]   sample_count_ff, min_samples_ff, max_err_frac_ff;
   logic [23:0]             counts_per_g_ff, good_sigma_ff, degr_sigma_ff;

   // run state
   state_type               state_ff, state_in;
   logic                    run_active_ff, run_active_in;
   logic [COUNT_BITS-1:0]   items_ff, items_in;
   logic [COUNT_BITS-1:0]   valid_ff, valid_in;
   logic [COUNT_BITS-1:0]   errors_ff, errors_in;
   logic [COUNT_BITS-1:0]   run_len_ff, run_len_in;
   logic [MEAN_BITS-1:0]    mean_ff, mean_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;

   // serial datapath
   logic [MEAN_BITS-1:0]    x_ff, x_in;
   logic                    dneg_ff, dneg_in;
   logic [DELTA_BITS-1:0]   mul_a_ff, mul_a_in;
   logic [DELTA_BITS-1:0]   mul_b_ff, mul_b_in;
   logic [DELTA_BITS:0]     mul_hi_ff, mul_hi_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic [SUM_BITS-1:0]     sq_v_ff, sq_v_in;
   logic [SIGMA_BITS-1:0]   sq_rem_ff, sq_rem_in;
   logic [SIGMA_BITS-1:0]   sq_root_ff, sq_root_in;
   logic [SIGMA_BITS-1:0]   sg_ff, sg_in;

   // result
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_data_type            rsp_ff, rsp_in;

   // divider hookup
   logic                    div_start;
   logic [DIV_BITS-1:0]     div_dividend;
   logic [DIVISOR_BITS-1:0] div_divisor;
   logic                    div_done;
   logic [DIV_BITS-1:0]     div_q;

   nfwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // helper terms
   logic                    accept;
   logic [MEAN_BITS-1:0]    x_new;
   logic [DELTA_BITS-1:0]   delta;
   logic [DELTA_BITS-1:0]   delta_mag;
   logic [DELTA_BITS-1:0]   q_ext;
   logic [MEAN_BITS-1:0]    mean_upd;
   logic [DELTA_BITS-1:0]   delta2;
   logic [DELTA_BITS:0]     mul_sum;
   logic [PROD_BITS-1:0]    product;
   logic [TERM_BITS-1:0]    term;
   logic [SUM_BITS:0]       sum_add;
   logic [2*COUNT_BITS-1:0] err_lhs, err_rhs;
   logic                    err_abort;
   logic                    run_done;
   logic                    var_sat;
   logic [SIGMA_BITS+1:0]   sq_sh, sq_trial;
   logic                    sq_fit;
   logic                    too_few;

   always_comb begin
      accept    = start && !busy;
      x_new     = {req_data.sample, {MEAN_FRAC_BITS{1'b0}}};
      delta     = {x_ff[MEAN_BITS-1], x_ff} - {mean_ff[MEAN_BITS-1], mean_ff};
      delta_mag = delta[DELTA_BITS-1] ? -delta : delta;
      q_ext     = div_q[DELTA_BITS-1:0];
      mean_upd  = MEAN_BITS'({mean_ff[MEAN_BITS-1], mean_ff} + (dneg_ff ? -q_ext : q_ext));
      delta2    = {x_ff[MEAN_BITS-1], x_ff} - {mean_upd[MEAN_BITS-1], mean_upd};
      mul_sum   = mul_hi_ff + (mul_b_ff[0] ? {1'b0, mul_a_ff} : '0);
      product   = {mul_hi_ff[DELTA_BITS-1:0], mul_b_ff};
      term      = product[PROD_BITS-1:PROD_SHIFT];
      sum_add   = {1'b0, sum_ff} + {(SUM_BITS+1-TERM_BITS)'(0), term};
      err_lhs   = {errors_ff, {COUNT_BITS{1'b0}}};
      err_rhs   = (2*COUNT_BITS)'(max_err_frac_ff) * (2*COUNT_BITS)'(run_len_ff);
      err_abort = err_lhs > err_rhs;
      run_done  = items_ff >= run_len_ff;
      var_sat   = |div_q[DIV_BITS-1:52];
      sq_sh     = {sq_rem_ff, sq_v_ff[SUM_BITS-1 -: 2]};
      sq_trial  = {sq_root_ff, 2'b01};
      sq_fit    = sq_sh >= sq_trial;
      too_few   = sample_count_ff < min_samples_ff;
   end

   assign busy = state_ff != S_IDLE;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && !req_data.req_type && run_active_ff) begin
               state_in = req_data.read_error ? S_ERRCHK : S_DIV_MEAN;
            end
         end
         S_DIV_MEAN: begin
            if (div_done) state_in = S_MUL;
         end
         S_MUL: begin
            if (cnt_ff == 6'(DELTA_BITS)) state_in = S_CHECK;
         end
         S_ERRCHK: state_in = err_abort ? S_IDLE : S_CHECK;
         S_CHECK:  state_in = run_done ? S_FIN : S_IDLE;
         S_FIN:    state_in = (valid_ff < COUNT_BITS'(MIN_VALID)) ? S_IDLE : S_VAR;
         S_VAR: begin
            if (div_done) state_in = var_sat ? S_QUAL : S_SQRT;
         end
         S_SQRT: begin
            if (cnt_ff == 6'(SIGMA_BITS - 1)) begin
               state_in = (counts_per_g_ff == '0) ? S_QUAL : S_GDIV;
            end
         end
         S_GDIV: begin
            if (div_done) state_in = S_QUAL;
         end
         S_QUAL:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      run_active_in = run_active_ff;
      items_in      = items_ff;
      valid_in      = valid_ff;
      errors_in     = errors_ff;
      run_len_in    = run_len_ff;
      mean_in       = mean_ff;
      sum_in        = sum_ff;
      x_in          = x_ff;
      dneg_in       = dneg_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      mul_hi_in     = mul_hi_ff;
      cnt_in        = cnt_ff;
      sq_v_in       = sq_v_ff;
      sq_rem_in     = sq_rem_ff;
      sq_root_in    = sq_root_ff;
      sg_in         = sg_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      div_start     = 1'b0;
      div_dividend  = {(DIV_BITS-DELTA_BITS)'(0), delta_mag};
      div_divisor   = {(DIVISOR_BITS-COUNT_BITS)'(0), valid_ff};
      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.req_type) begin
               // open a run
               items_in  = '0;
               valid_in  = '0;
               errors_in = '0;
               mean_in   = '0;
               sum_in    = '0;
               if (too_few) begin
                  run_active_in = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_in        = '{ST_TOO_FEW, Q_FAILED, '0, '0, '0, '0};
               end else begin
                  run_len_in    = sample_count_ff;
                  run_active_in = 1'b1;
                  if (sample_count_ff == '0) begin
                     run_active_in = 1'b0;
                     rsp_valid_in  = 1'b1;
                     rsp_in        = '{ST_FEW_VALID, Q_FAILED, '0, '0, '0, '0};
                  end
               end
            end else if (accept && run_active_ff) begin
               items_in = items_ff + 1'b1;
               cnt_in   = '0;
               if (req_data.read_error) begin
                  errors_in = errors_ff + 1'b1;
               end else begin
                  valid_in = valid_ff + 1'b1;
                  x_in     = x_new;
               end
            end
         end
         S_DIV_MEAN: begin
            // start the mean divide on entry, once the sample is registered in x_ff
            div_start = (cnt_ff == '0) && !div_done;
            cnt_in    = 6'd1;
            if (div_start) dneg_in = delta[DELTA_BITS-1];
            if (div_done) begin
               mean_in   = mean_upd;
               mul_a_in  = delta_mag;
               mul_b_in  = delta2[DELTA_BITS-1] ? -delta2 : delta2;
               mul_hi_in = '0;
               cnt_in    = '0;
            end
         end
         S_MUL: begin
            // shift-add multiply, one multiplier bit per cycle
            if (cnt_ff == 6'(DELTA_BITS)) begin
               sum_in = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
               cnt_in = '0;
            end else begin
               {mul_hi_in, mul_b_in} = {1'b0, mul_sum, mul_b_ff[DELTA_BITS-1:1]};
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ERRCHK: begin
            if (err_abort) begin
               run_active_in = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_in        = '{ST_READ_ERR, Q_FAILED, '0, '0, valid_ff, errors_ff};
            end
         end
         S_CHECK: begin
            cnt_in = '0;
         end
         S_FIN: begin
            if (valid_ff < COUNT_BITS'(MIN_VALID)) begin
               run_active_in = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_in        = '{ST_FEW_VALID, Q_FAILED, '0, '0, valid_ff, errors_ff};
            end else begin
               div_start    = 1'b1;
               div_dividend = sum_ff;
               div_divisor  = {(DIVISOR_BITS-COUNT_BITS)'(0), valid_ff - 1'b1};
            end
         end
         S_VAR: begin
            if (div_done) begin
               sq_v_in    = {div_q[51:0], 12'b0};
               sq_rem_in  = '0;
               sq_root_in = '0;
               cnt_in     = '0;
               if (var_sat) begin
                  sq_root_in = '1;
                  sg_in      = '1;
               end
            end
         end
         S_SQRT: begin
            // two radicand bits per cycle, partial remainder stays below 2^32 until the unused last step
            sq_v_in    = {sq_v_ff[SUM_BITS-3:0], 2'b00};
            sq_rem_in  = sq_fit ? SIGMA_BITS'(sq_sh - sq_trial) : sq_sh[SIGMA_BITS-1:0];
            sq_root_in = {sq_root_ff[SIGMA_BITS-2:0], sq_fit};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == 6'(SIGMA_BITS - 1)) begin
               if (counts_per_g_ff == '0) begin
                  sg_in = '1;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = {(DIV_BITS-SIGMA_BITS-8)'(0),
                                  sq_root_ff[SIGMA_BITS-2:0], sq_fit, 8'b0};
                  div_divisor  = counts_per_g_ff;
               end
            end
         end
         S_GDIV: begin
            if (div_done) begin
               sg_in = (|div_q[DIV_BITS-1:SIGMA_BITS]) ? '1 : div_q[SIGMA_BITS-1:0];
            end
         end
         S_QUAL: begin
            run_active_in = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_in.status       = ST_COMPLETED;
            rsp_in.sigma_counts = sq_root_ff;
            rsp_in.sigma_grams  = sg_ff;
            rsp_in.valid_total  = valid_ff;
            rsp_in.error_total  = errors_ff;
            if (sg_ff < {8'b0, good_sigma_ff}) rsp_in.quality = Q_GOOD;
            else if (sg_ff < {8'b0, degr_sigma_ff}) rsp_in.quality = Q_DEGRADED;
            else rsp_in.quality = Q_FAILED;
         end
         default: begin
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= 16'd100;
         min_samples_ff  <= 16'd2;
         max_err_frac_ff <= 16'd3277;
         counts_per_g_ff <= 24'd107520;
         good_sigma_ff   <= 24'd128;
         degr_sigma_ff   <= 24'd512;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_MIN_SAMPLES:  min_samples_ff  <= csr_wdata[COUNT_BITS-1:0];
            CSR_MAX_ERR_FRAC: max_err_frac_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_COUNTS_PER_G: counts_per_g_ff <= csr_wdata;
            CSR_GOOD_SIGMA:   good_sigma_ff   <= csr_wdata;
            CSR_DEGR_SIGMA:   degr_sigma_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         run_active_ff <= 1'b0;
         items_ff      <= '0;
         valid_ff      <= '0;
         errors_ff     <= '0;
         run_len_ff    <= '0;
         mean_ff       <= '0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_active_ff <= run_active_in;
         items_ff      <= items_in;
         valid_ff      <= valid_in;
         errors_ff     <= errors_in;
         run_len_ff    <= run_len_in;
         mean_ff       <= mean_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x_ff       <= x_in;
      dneg_ff    <= dneg_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      mul_hi_ff  <= mul_hi_in;
      sq_v_ff    <= sq_v_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      sg_ff      <= sg_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
